// ===== design/sbus_pkg.sv =====
// shared types and constants of the sbus frame decoder
package sbus_pkg;

	localparam int FRAME_BYTES = 25;
	localparam int WIN_DEPTH   = FRAME_BYTES - 1;
	localparam int NUM_CH      = 16;
	localparam int CH_BITS     = 11;
	localparam int DATA_BITS   = NUM_CH * CH_BITS;
	localparam int FLAG_BITS   = 4;
	localparam int FLAG_BYTE   = WIN_DEPTH - 1;
	localparam int CNT_BITS    = $clog2(WIN_DEPTH + 1);
	localparam int CH_IDX_BITS = $clog2(NUM_CH);

	// register indexes on the configuration port
	localparam logic REG_HEADER = 1'b0;
	localparam logic REG_FOOTER = 1'b1;

	// reset values of the registers
	localparam logic [7:0] HEADER_RESET = 8'h0f;
	localparam logic [7:0] FOOTER_RESET = 8'h00;

	// one captured frame: packed channel bits and the flag nibble
	typedef struct packed {
		logic [FLAG_BITS-1:0] flags;
		logic [DATA_BITS-1:0] chans;
	} frame_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== design/sbus_front.sv =====
// front part: byte window, frame match and frame capture
module sbus_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          header_byte,
	input  logic [7:0]          footer_byte,
	output logic                push,
	output sbus_pkg::frame_t    frame
);

	logic [7:0]                    win_q [0:sbus_pkg::WIN_DEPTH-1];
	logic [sbus_pkg::CNT_BITS-1:0] fill_q;
	logic                          full;
	logic                          match;

	// match needs a full window, header at the old end and footer arriving
	assign full  = (fill_q == sbus_pkg::CNT_BITS'(sbus_pkg::WIN_DEPTH));
	assign match = full && (win_q[0] == header_byte) && (rx_byte == footer_byte);
	assign push  = accept && match;

	// frame bytes 1 to 22 packed little-endian, flags from byte 23
	always_comb begin
		for (int k = 1; k <= sbus_pkg::FLAG_BYTE - 1; k++) begin
			frame.chans[8*(k-1) +: 8] = win_q[k];
		end
		frame.flags = win_q[sbus_pkg::FLAG_BYTE][sbus_pkg::FLAG_BITS-1:0];
	end

	// window shifts in at the young end
	always_ff @(posedge clk) begin
		if (accept && !match) begin
			for (int i = 0; i < sbus_pkg::WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sbus_pkg::WIN_DEPTH-1] <= rx_byte;
		end
	end

	// fill count saturates when full, clears on a match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (match) begin
				fill_q <= '0;
			end else if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

// ===== design/sbus_fifo.sv =====
// two-entry frame queue between front and back
module sbus_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sbus_pkg::frame_t      wr_frame,
	input  logic                  pop,
	output sbus_pkg::frame_t      rd_frame,
	output sbus_pkg::fifo_stat_t  stat
);

	sbus_pkg::frame_t mem_q [0:1];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign rd_frame   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_frame;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// no push into a full queue, no pop from an empty one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push) else $error("push into full frame queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop) else $error("pop from empty frame queue");

endmodule

// ===== design/sbus_back.sv =====
// back part: walks the 16 channels of a queued frame into the result register
module sbus_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sbus_pkg::fifo_stat_t                 stat,
	input  sbus_pkg::frame_t                     rd_frame,
	output logic                                 pop,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [sbus_pkg::CH_IDX_BITS-1:0]     channel_index,
	output logic [sbus_pkg::CH_BITS-1:0]         channel_value,
	output logic                                 digital_ch17,
	output logic                                 digital_ch18,
	output logic                                 frame_lost,
	output logic                                 failsafe,
	output logic                                 remote_lost,
	output logic                                 last_of_frame
);

	logic                                busy_q;
	logic [sbus_pkg::DATA_BITS-1:0]      data_q;
	logic [sbus_pkg::FLAG_BITS-1:0]      flags_q;
	logic [sbus_pkg::CH_IDX_BITS-1:0]    ch_q;
	logic                                res_valid_q;
	logic                                out_free;
	logic                                step;
	logic                                last_ch;

	assign out_free = !res_valid_q || !res_stall;
	assign step     = busy_q && out_free;
	assign pop      = !busy_q && !stat.empty;
	assign last_ch  = (ch_q == sbus_pkg::CH_IDX_BITS'(sbus_pkg::NUM_CH - 1));
	assign res_valid = res_valid_q;

	// frame walker: current channel sits in the low bits
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q  <= rd_frame.chans;
			flags_q <= rd_frame.flags;
		end else if (step) begin
			data_q <= {sbus_pkg::CH_BITS'(0), data_q[sbus_pkg::DATA_BITS-1:sbus_pkg::CH_BITS]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			ch_q   <= '0;
		end else if (step) begin
			ch_q <= ch_q + 1'b1;
			if (last_ch) begin
				busy_q <= 1'b0;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (step) begin
			channel_index <= ch_q;
			channel_value <= data_q[sbus_pkg::CH_BITS-1:0];
			digital_ch17  <= flags_q[0];
			digital_ch18  <= flags_q[1];
			frame_lost    <= flags_q[2];
			failsafe      <= flags_q[3];
			remote_lost   <= flags_q[2] | flags_q[3];
			last_of_frame <= last_ch;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// last marker only on the final channel
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && last_of_frame) |->
		(channel_index == sbus_pkg::CH_IDX_BITS'(sbus_pkg::NUM_CH - 1)))
		else $error("last_of_frame on wrong channel");
	// a request that is not the last leaves the frame walker busy
	a_busy_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !last_of_frame) |-> busy_q)
		else $error("frame walker idle in mid frame");
	// no new frame is taken while one is being walked
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy_q && !step)) else $error("frame popped while busy");

endmodule

// ===== design/sbus_frame_decoder.sv =====
// top level of the sbus frame decoder
//
// Receive side: rx_valid / rx_stall carry one serial byte (rx_byte) per request.
// The block keeps the last 24 bytes; when the window is full, its oldest byte
// equals header_byte and the new byte equals footer_byte, a frame is found and
// 16 result requests follow on res_valid / res_stall, one per channel in order,
// with last_of_frame set on channel 15. The fill count then clears.
// While rx_stall is low a byte is taken every cycle; a matched frame is copied
// into a two-entry queue, so rx_stall rises only while two frames wait there.
// The first result is registered after the footer byte is taken, via the queue
// and the walker; with res_stall low the back end gives one result per cycle,
// and the single channel walker pops the next frame only after the current one.
// With a result held and res_stall high, the result register holds and the
// walker waits; the receive side keeps taking bytes until the queue fills.
// Reset (arst_n low) empties window, queue and result register and sets
// header_byte to 0x0f and footer_byte to 0x00. Registers are written over the
// APB port: header_byte at address 0, footer_byte at address 4.
module sbus_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        digital_ch17,
	output logic        digital_ch18,
	output logic        frame_lost,
	output logic        failsafe,
	output logic        remote_lost,
	output logic        last_of_frame
);

	logic [7:0]           header_q;
	logic [7:0]           footer_q;
	logic                 cfg_wr;
	logic                 rx_accept;
	logic                 push;
	logic                 pop;
	sbus_pkg::frame_t     wr_frame;
	sbus_pkg::frame_t     rd_frame;
	sbus_pkg::fifo_stat_t stat;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= sbus_pkg::HEADER_RESET;
			footer_q <= sbus_pkg::FOOTER_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				sbus_pkg::REG_HEADER: header_q <= pwdata[7:0];
				sbus_pkg::REG_FOOTER: footer_q <= pwdata[7:0];
				default:              header_q <= header_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			sbus_pkg::REG_HEADER: prdata = {24'h0, header_q};
			sbus_pkg::REG_FOOTER: prdata = {24'h0, footer_q};
			default:              prdata = 32'h0;
		endcase
	end

	// receive handshake
	assign rx_stall  = stat.full;
	assign rx_accept = rx_valid && !rx_stall;

	sbus_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (rx_accept),
		.rx_byte     (rx_byte),
		.header_byte (header_q),
		.footer_byte (footer_q),
		.push        (push),
		.frame       (wr_frame)
	);

	sbus_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (wr_frame),
		.pop      (pop),
		.rd_frame (rd_frame),
		.stat     (stat)
	);

	sbus_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stat          (stat),
		.rd_frame      (rd_frame),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.digital_ch17  (digital_ch17),
		.digital_ch18  (digital_ch18),
		.frame_lost    (frame_lost),
		.failsafe      (failsafe),
		.remote_lost   (remote_lost),
		.last_of_frame (last_of_frame)
	);

endmodule
